### rtl/core/lkr_pkg.sv
package lkr_pkg;

  localparam int NumFrames = 64;
  localparam int FrameW    = 6;
  localparam int CountW    = 4;
  localparam int StampW    = 32;
  localparam int TotalW    = 7;
  localparam int IdxW      = $clog2(NumFrames + 1);
  localparam int QDepth    = 2;
  localparam logic [CountW-1:0] KReset = 4'd2;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SETEV  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [FrameW-1:0] frame;
    logic              evictable_flag;
  } item_t;

  typedef struct packed {
    logic              victim_found;
    logic [FrameW-1:0] victim_frame;
    logic [TotalW-1:0] evictable_count;
  } result_t;

endpackage

### rtl/core/lkr_front.sv
module lkr_front import lkr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_data_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  item_t             q_mem [QDepth];
  logic              wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]        fill_q, fill_d;
  logic              push;
  item_t             in_item;

  always_comb begin
    in_item.op             = op_e'(in_data_i[1:0]);
    in_item.frame          = in_data_i[7:2];
    in_item.evictable_flag = in_data_i[8];
  end

  assign in_ready_o   = (fill_q != 2'(QDepth));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = (item_pop_i && item_valid_o) ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(item_pop_i && item_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

endmodule

### rtl/core/lkr_back.sv
module lkr_back import lkr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;
  localparam int EntW = StampW + CountW;

  logic [1:0]           state_q, state_d;
  logic [CountW-1:0]    k_q;
  logic [CountW-1:0]    eff_k;
  logic [NumFrames-1:0] trk_q, trk_d, ev_q, ev_d;
  logic [TotalW-1:0]    total_q, total_d;
  logic [StampW-1:0]    stamp_q, stamp_d;
  item_t                cur_q, cur_d;
  logic [EntW-1:0]      mem [NumFrames];
  logic [EntW-1:0]      rd_q;
  logic [FrameW-1:0]    rd_addr;
  logic                 wr_en;
  logic [FrameW-1:0]    wr_addr;
  logic [EntW-1:0]      wr_data;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 p_vld_q, p_vld_d;
  logic [FrameW-1:0]    p_idx_q, p_idx_d;
  logic                 lo_f_q, lo_f_d, hi_f_q, hi_f_d;
  logic [FrameW-1:0]    lo_i_q, lo_i_d, hi_i_q, hi_i_d;
  logic [StampW-1:0]    lo_a_q, lo_a_d, hi_a_q, hi_a_d;
  logic                 rv_q, rv_d;
  result_t              res_q, res_d;
  logic [CountW-1:0]    old_cnt, new_cnt, p_cnt;
  logic [StampW-1:0]    p_age;
  logic                 p_sat, p_ok;
  logic                 vic_f;
  logic [FrameW-1:0]    vic_i;

  assign eff_k       = (k_q == '0) ? CountW'(1) : k_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign p_cnt       = rd_q[CountW-1:0];
  assign p_age       = stamp_q - rd_q[EntW-1:CountW];
  assign p_sat       = (p_cnt >= eff_k);
  assign p_ok        = p_vld_q && trk_q[p_idx_q] && ev_q[p_idx_q];
  assign old_cnt     = trk_q[cur_q.frame] ? rd_q[CountW-1:0] : '0;
  assign vic_f       = lo_f_q || hi_f_q;
  assign vic_i       = lo_f_q ? lo_i_q : (hi_f_q ? hi_i_q : '0);

  always_comb begin
    if (!trk_q[cur_q.frame]) begin
      new_cnt = CountW'(1);
    end else if (old_cnt < eff_k) begin
      new_cnt = old_cnt + CountW'(1);
    end else begin
      new_cnt = old_cnt;
    end
  end

  always_comb begin
    state_d    = state_q;
    trk_d      = trk_q;
    ev_d       = ev_q;
    total_d    = total_q;
    stamp_d    = stamp_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    lo_f_d     = lo_f_q;
    lo_i_d     = lo_i_q;
    lo_a_d     = lo_a_q;
    hi_f_d     = hi_f_q;
    hi_i_d     = hi_i_q;
    hi_a_d     = hi_a_q;
    rv_d       = rv_q && !res_ready_i;
    res_d      = res_q;
    item_pop_o = 1'b0;
    rd_addr    = item_i.frame;
    wr_en      = 1'b0;
    wr_addr    = cur_q.frame;
    wr_data    = {stamp_q + StampW'(1), new_cnt};
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i && !rv_q) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          idx_d      = '0;
          lo_f_d     = 1'b0;
          hi_f_d     = 1'b0;
          lo_a_d     = '0;
          hi_a_d     = '0;
          state_d    = (item_i.op == OP_EVICT) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        res_d.victim_found = 1'b0;
        res_d.victim_frame = '0;
        unique case (cur_q.op)
          OP_ACCESS: begin
            wr_en   = 1'b1;
            stamp_d = stamp_q + StampW'(1);
            if (!trk_q[cur_q.frame]) begin
              trk_d[cur_q.frame] = 1'b1;
              ev_d[cur_q.frame]  = 1'b0;
            end
          end
          OP_SETEV: begin
            if (trk_q[cur_q.frame]) begin
              if (!ev_q[cur_q.frame] && cur_q.evictable_flag) begin
                total_d = total_q + TotalW'(1);
              end else if (ev_q[cur_q.frame] && !cur_q.evictable_flag) begin
                total_d = total_q - TotalW'(1);
              end
              ev_d[cur_q.frame] = cur_q.evictable_flag;
            end
          end
          OP_REMOVE: begin
            if (trk_q[cur_q.frame] && ev_q[cur_q.frame]) begin
              trk_d[cur_q.frame] = 1'b0;
              ev_d[cur_q.frame]  = 1'b0;
              total_d            = total_q - TotalW'(1);
            end
          end
          default: begin
          end
        endcase
        res_d.evictable_count = total_d;
        rv_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        rd_addr = idx_q[FrameW-1:0];
        if (idx_q != IdxW'(NumFrames)) begin
          p_vld_d = 1'b1;
          p_idx_d = idx_q[FrameW-1:0];
          idx_d   = idx_q + IdxW'(1);
        end
        if (p_ok) begin
          if (p_sat) begin
            if (!hi_f_q || p_age > hi_a_q) begin
              hi_f_d = 1'b1;
              hi_i_d = p_idx_q;
              hi_a_d = p_age;
            end
          end else if (!lo_f_q || p_age > lo_a_q) begin
            lo_f_d = 1'b1;
            lo_i_d = p_idx_q;
            lo_a_d = p_age;
          end
        end
        if (p_vld_q && p_idx_q == FrameW'(NumFrames - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (vic_f) begin
          trk_d[vic_i] = 1'b0;
          ev_d[vic_i]  = 1'b0;
          total_d      = total_q - TotalW'(1);
        end
        res_d.victim_found    = vic_f;
        res_d.victim_frame    = vic_i;
        res_d.evictable_count = total_d;
        rv_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= KReset;
      trk_q   <= '0;
      ev_q    <= '0;
      total_q <= '0;
      stamp_q <= '0;
      rv_q    <= 1'b0;
      p_vld_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
      trk_q   <= trk_d;
      ev_q    <= ev_d;
      total_q <= total_d;
      stamp_q <= stamp_d;
      rv_q    <= rv_d;
      p_vld_q <= p_vld_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    p_idx_q <= p_idx_d;
    lo_f_q  <= lo_f_d;
    lo_i_q  <= lo_i_d;
    lo_a_q  <= lo_a_d;
    hi_f_q  <= hi_f_d;
    hi_i_q  <= hi_i_d;
    hi_a_q  <= hi_a_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

### rtl/core/lru_k_frame_replacer.sv
// Channel | Dir | Handshake             | Payload
// s_axis  | in  | s_axis_tvalid/tready  | s_axis_tdata: op, frame, evictable_flag
// m_axis  | out | m_axis_tvalid/tready  | m_axis_tdata: victim_found, victim_frame, count
// cfg     | in  | cfg_valid/cfg_ready   | cfg_data: k_threshold
//
// Access, set evictable and remove pass from the queue head through the IDLE and EXEC states to the result.
// Evict scans the frames in the SCAN state: one frame of the stamp memory is read and compared per cycle.
// A two-beat input queue takes beats until full while a result waits at the output.
// Reset clears all frame flags, the stamp counter and sets k_threshold to 2.
module lru_k_frame_replacer import lkr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], frame[7:2], evictable_flag[8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // victim_found[0], victim_frame[6:1], count[13:7]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic    item_valid, item_pop;
  item_t   item;
  result_t res;

  assign cfg_ready = 1'b1;

  lkr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  lkr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_data_i   (cfg_data),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {2'b00, res.evictable_count, res.victim_frame, res.victim_found};

endmodule

### rtl/core/lkr_checker.sv
module lkr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_ready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("victim frame set without a victim");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:7] <= 7'd64 && m_axis_tdata[15:14] == 2'b00)
    else $error("evictable count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("config channel not ready");

endmodule

bind lru_k_frame_replacer lkr_checker u_lkr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
